// ===== rtl/tkwds_pkg.sv =====
// Package for the weighted top-k site selector: op codes, sequencer states, widths.
// No dependencies.
`timescale 1ns / 1ps
package tkwds_pkg;
  localparam int CoordW = 16;
  localparam int DistW  = 18;
  localparam int SqW    = 34;
  localparam int RootW  = 17;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL_X,
    ST_MUL_Y,
    ST_SQRT,
    ST_INS,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT,
    ST_EMPTY
  } state_t;
endpackage

// ===== rtl/tkwds_sqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on tkwds_pkg.
`timescale 1ns / 1ps
module tkwds_sqrt import tkwds_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SqW-1:0]   radicand,
  output logic             done,
  output logic [RootW-1:0] root
);
  localparam int StepW = $clog2(RootW + 1);

  logic [RootW-1:0] rem_r, rem_nxt;
  logic [RootW-1:0] root_r, root_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic             busy_r, busy_nxt;
  logic [RootW+1:0] trial;
  logic [RootW+1:0] part;

  // part: current remainder window bits, shifted in two at a time
  always_comb begin
    part  = {rem_r, radicand[2*step_r-1 -: 2]};
    trial = {root_r, 2'b01};
    rem_nxt  = rem_r;
    root_nxt = root_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      root_nxt = '0;
      step_nxt = StepW'(RootW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (part >= trial) begin
        rem_nxt  = RootW'(part - trial);
        root_nxt = {root_r[RootW-2:0], 1'b1};
      end else begin
        rem_nxt  = RootW'(part);
        root_nxt = {root_r[RootW-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == StepW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = busy_r && (step_r == StepW'(1));
  assign root = {root_r[RootW-2:0], (part >= trial)};
endmodule

// ===== rtl/topk_weighted_distance_select_top.sv =====
// Weighted top-k site selector: clear, load or query one item at a time.
// A query reads every loaded site in turn and then gives its n results:
// each site goes through one shared multiplier twice and a 17-step bit-serial root.
// Results then leave one per accepted beat, held while out_ready is low. Reset (rst_n,
// synchronous) empties the table, sets top_count to 1; the site memory is not cleared.
// Depends on tkwds_pkg and tkwds_sqrt.
`timescale 1ns / 1ps
module topk_weighted_distance_select_top import tkwds_pkg::*; #(
  parameter int MAX_SITES = 1024,
  parameter int MAX_TOP   = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [3:0]               cfg_top_count,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_op,
  input  logic signed [CoordW-1:0] in_coord_x,
  input  logic signed [CoordW-1:0] in_coord_y,
  input  logic [CoordW-1:0]        in_site_weight_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_rank,
  output logic signed [CoordW-1:0] out_found_x,
  output logic signed [CoordW-1:0] out_found_y,
  output logic [CoordW-1:0]        out_found_weight,
  output logic signed [DistW-1:0]  out_weighted_distance,
  output logic                     out_empty_res,
  output logic                     out_last
);
  localparam int AW   = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int CntW = $clog2(MAX_SITES + 1);
  localparam int TW   = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
  localparam int KW   = $clog2(MAX_TOP + 1);

  logic [3*CoordW-1:0] mem [MAX_SITES];
  logic [3*CoordW-1:0] rd_q;
  logic [AW-1:0]       rd_addr;

  state_t state_r, state_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [3:0]      topc_r;
  logic [KW-1:0]   k_r, k_nxt;
  logic [KW-1:0]   n_r, n_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic [KW-1:0]   oi_r, oi_nxt;
  logic signed [CoordW-1:0] qx_r, qy_r;
  logic signed [CoordW:0]   dx_c, dy_c;
  logic [SqW-1:0]  sq_r, sq_nxt;
  logic [CoordW-1:0] w_r;
  logic signed [DistW-1:0] val_r;
  logic signed [DistW-1:0] bv_r [MAX_TOP];
  logic [AW-1:0]           bi_r [MAX_TOP];
  logic             sq_start, sq_done;
  logic [RootW-1:0] root;
  logic signed [CoordW:0] mul_a;
  logic [2*CoordW+1:0]   prod;

  // site data stays on rd_q while the multiplier works on it
  assign dx_c = (CoordW+1)'($signed(rd_q[3*CoordW-1 -: CoordW])) - (CoordW+1)'(qx_r);
  assign dy_c = (CoordW+1)'($signed(rd_q[2*CoordW-1 -: CoordW])) - (CoordW+1)'(qy_r);

  // one shared multiplier squares dx, then dy
  assign mul_a = (state_r == ST_MUL_X) ? dx_c : dy_c;
  assign prod  = (2*CoordW+2)'(mul_a * mul_a);

  tkwds_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_r),
    .done(sq_done), .root(root)
  );

  // hold the reported site's address until its beat leaves
  assign rd_addr = (state_r == ST_OUT_RD || state_r == ST_OUT_WAIT || state_r == ST_OUT) ?
                   bi_r[oi_r[TW-1:0]] : idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && op_t'(in_op) == OP_LOAD && count_r < CntW'(MAX_SITES))
      mem[count_r[AW-1:0]] <= {in_coord_x, in_coord_y, in_site_weight_in};
    rd_q <= mem[rd_addr];
  end

  // insertion into the sorted best list; k entries at most
  logic [KW-1:0] pos;
  always_comb begin
    pos = n_r;
    for (int j = MAX_TOP - 1; j >= 0; j--)
      if (KW'(j) < n_r && val_r < bv_r[j]) pos = KW'(j);
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    k_nxt = k_r;
    n_nxt = n_r;
    idx_nxt = idx_r;
    oi_nxt = oi_r;
    sq_nxt = sq_r;
    sq_start = 1'b0;
    in_ready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        unique case (op_t'(in_op))
          OP_CLEAR: count_nxt = '0;
          OP_LOAD: if (count_r < CntW'(MAX_SITES)) count_nxt = count_r + 1'b1;
          OP_QUERY: begin
            idx_nxt = '0;
            n_nxt = '0;
            if (topc_r == 4'd0) k_nxt = KW'(1);
            else if (int'(topc_r) > MAX_TOP) k_nxt = KW'(MAX_TOP);
            else k_nxt = KW'(topc_r);
            state_nxt = (count_r == '0) ? ST_EMPTY : ST_RD;
          end
          OP_NONE: ;
          default: ;
        endcase
      end
      ST_RD: state_nxt = ST_MUL_X;
      ST_MUL_X: begin
        sq_nxt = SqW'(prod);
        state_nxt = ST_MUL_Y;
      end
      // kick the root unit now; sq_r is final by its first step
      ST_MUL_Y: begin
        sq_nxt = sq_r + SqW'(prod);
        sq_start = 1'b1;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (sq_done) state_nxt = ST_INS;
      end
      ST_INS: begin
        if (pos < k_r && n_r < k_r) n_nxt = n_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
        oi_nxt = '0;
        state_nxt = (idx_r + 1'b1 == count_r) ? ST_OUT_RD : ST_RD;
      end
      ST_OUT_RD: state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT: state_nxt = ST_OUT;
      ST_OUT: if (out_ready) begin
        oi_nxt = oi_r + 1'b1;
        state_nxt = (oi_r + 1'b1 == n_r) ? ST_IDLE : ST_OUT_RD;
      end
      ST_EMPTY: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      topc_r  <= 4'd1;
      n_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      n_r <= n_nxt;
      if (cfg_we) topc_r <= cfg_top_count;
    end
    k_r <= k_nxt;
    idx_r <= idx_nxt;
    oi_r <= oi_nxt;
    sq_r <= sq_nxt;
    if (in_valid && in_ready) begin
      qx_r <= in_coord_x;
      qy_r <= in_coord_y;
    end
    if (state_r == ST_MUL_X) w_r <= rd_q[CoordW-1:0];
    if (sq_done) val_r <= DistW'($signed({1'b0, root})) - DistW'($signed({1'b0, w_r}));
    if (state_r == ST_INS && pos < k_r) begin
      for (int j = MAX_TOP - 1; j > 0; j--)
        if (KW'(j) > pos) begin
          bv_r[j] <= bv_r[j-1];
          bi_r[j] <= bi_r[j-1];
        end
      bv_r[pos[TW-1:0]] <= val_r;
      bi_r[pos[TW-1:0]] <= idx_r[AW-1:0];
    end
  end

  assign out_valid = (state_r == ST_OUT) || (state_r == ST_EMPTY);
  assign out_empty_res = (state_r == ST_EMPTY);
  assign out_last = out_empty_res || (oi_r + 1'b1 == n_r);
  assign out_rank = out_empty_res ? 3'd0 : 3'(oi_r);
  assign out_found_x = out_empty_res ? '0 : rd_q[3*CoordW-1 -: CoordW];
  assign out_found_y = out_empty_res ? '0 : rd_q[2*CoordW-1 -: CoordW];
  assign out_found_weight = out_empty_res ? '0 : rd_q[CoordW-1:0];
  assign out_weighted_distance = out_empty_res ? '0 : bv_r[oi_r[TW-1:0]];
endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for topk_weighted_distance_select_top: drives clear/load/query beats,
// predicts the k nearest weighted sites per query, and compares every result beat.
// Depends on tkwds_pkg and the RTL of the selector.
`timescale 1ns / 1ps

typedef struct {
  logic [2:0]         rank;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic [15:0]        weight;
  logic signed [17:0] wdist;
  logic               empty;
  logic               last;
} site_hit_t;

class nearest_site_board;
  localparam int Depth = 1024;
  localparam int TopMax = 8;
  logic [15:0] site_x[Depth];
  logic [15:0] site_y[Depth];
  logic [15:0] site_w[Depth];
  int          num_sites;
  int          k_reg;
  site_hit_t   hits_due[$];
  int          errors;
  int          hits_seen;
  int          queries;

  function new();
    num_sites = 0;
    k_reg = 1;
    errors = 0;
    hits_seen = 0;
    queries = 0;
  endfunction

  function longint unsigned floor_root(longint unsigned n);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function void note_input(tkwds_pkg::op_t op, logic [15:0] cx, logic [15:0] cy,
                           logic [15:0] w);
    int         k;
    int         vals[];
    bit         taken[];
    int         best;
    longint     dx;
    longint     dy;
    site_hit_t  h;
    case (op)
      tkwds_pkg::OP_CLEAR: num_sites = 0;
      tkwds_pkg::OP_LOAD: begin
        if (num_sites < Depth) begin
          site_x[num_sites] = cx;
          site_y[num_sites] = cy;
          site_w[num_sites] = w;
          num_sites++;
        end
      end
      tkwds_pkg::OP_QUERY: begin
        queries++;
        if (num_sites == 0) begin
          h = '{rank: '0, x: '0, y: '0, weight: '0, wdist: '0, empty: 1'b1, last: 1'b1};
          hits_due = {hits_due, h};
        end else begin
          k = (k_reg == 0) ? 1 : (k_reg > TopMax ? TopMax : k_reg);
          if (k > num_sites) k = num_sites;
          vals = new[num_sites];
          taken = new[num_sites];
          for (int i = 0; i < num_sites; i++) begin
            dx = longint'($signed(site_x[i])) - longint'($signed(cx));
            dy = longint'($signed(site_y[i])) - longint'($signed(cy));
            vals[i] = int'(floor_root(dx * dx + dy * dy)) - int'(site_w[i]);
          end
          // pick the smallest remaining value; strict compare keeps the lower index on ties
          for (int r = 0; r < k; r++) begin
            best = -1;
            for (int i = 0; i < num_sites; i++)
              if (!taken[i] && (best < 0 || vals[i] < vals[best])) best = i;
            taken[best] = 1'b1;
            h.rank = r[2:0];
            h.x = site_x[best];
            h.y = site_y[best];
            h.weight = site_w[best];
            h.wdist = vals[best][17:0];
            h.empty = 1'b0;
            h.last = (r == k - 1);
            hits_due = {hits_due, h};
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(site_hit_t got);
    site_hit_t want;
    hits_seen++;
    if (hits_due.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat: rank %0d dist %0d", got.rank, got.wdist);
      return;
    end
    want = hits_due.pop_front();
    if (got.rank !== want.rank || got.x !== want.x || got.y !== want.y ||
        got.weight !== want.weight || got.wdist !== want.wdist ||
        got.empty !== want.empty || got.last !== want.last) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch exp: rank %0d x %0d y %0d w %0d dist %0d empty %0b last %0b",
                 want.rank, want.x, want.y, want.weight, want.wdist, want.empty, want.last);
        $display("         act: rank %0d x %0d y %0d w %0d dist %0d empty %0b last %0b",
                 got.rank, got.x, got.y, got.weight, got.wdist, got.empty, got.last);
      end
    end
  endfunction
endclass

module testbench;
  import tkwds_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [3:0]         cfg_top_count;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_op;
  logic signed [15:0] in_coord_x;
  logic signed [15:0] in_coord_y;
  logic [15:0]        in_site_weight_in;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_rank;
  logic signed [15:0] out_found_x;
  logic signed [15:0] out_found_y;
  logic [15:0]        out_found_weight;
  logic signed [17:0] out_weighted_distance;
  logic               out_empty_res;
  logic               out_last;

  nearest_site_board board;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;
  int beats_sent;

  topk_weighted_distance_select_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_top_count(cfg_top_count),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_site_weight_in(in_site_weight_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_rank(out_rank),
    .out_found_x(out_found_x), .out_found_y(out_found_y),
    .out_found_weight(out_found_weight), .out_weighted_distance(out_weighted_distance),
    .out_empty_res(out_empty_res), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // result side: sample at the edge, then pick ready for the next cycle
  initial begin
    site_hit_t got;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = '{rank: out_rank, x: out_found_x, y: out_found_y, weight: out_found_weight,
                wdist: out_weighted_distance, empty: out_empty_res, last: out_last};
        board.check_result(got);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // call at a rising edge; returns at the edge where the beat was accepted
  task automatic send_beat(op_t op, logic [15:0] cx, logic [15:0] cy, logic [15:0] w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_coord_x <= cx;
    in_coord_y <= cy;
    in_site_weight_in <= w;
    do @(posedge clk); while (!in_ready);
    board.note_input(op, cx, cy, w);
    beats_sent++;
  endtask

  // hold until all results are back, plus slack for a trailing clear or load
  task automatic drain();
    in_valid <= 1'b0;
    while (board.hits_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_top_count(logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_top_count <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.k_reg = v;
  endtask

  function automatic logic [15:0] pick_coord(bit near);
    if (near) return 16'($signed($urandom_range(64)) - 32);
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly clear/load/query sequences with random content, plus some noise
  task automatic random_items(int n);
    int  done;
    bit  near;
    done = 0;
    while (done < n) begin
      if ($urandom_range(99) < 85) begin
        near = $urandom_range(1);
        if ($urandom_range(1)) begin
          send_beat(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
          done++;
        end
        repeat ($urandom_range(12, 1)) begin
          send_beat(OP_LOAD, pick_coord(near), pick_coord(near),
                    near ? 16'($urandom_range(16)) : 16'($urandom));
          done++;
        end
        repeat ($urandom_range(3, 1)) begin
          send_beat(OP_QUERY, pick_coord(near), pick_coord(near), 16'($urandom));
          done++;
        end
      end else begin
        case ($urandom_range(2))
          0: send_beat(OP_NONE, 16'($urandom), 16'($urandom), 16'($urandom));
          1: begin
            send_beat(OP_QUERY, 16'($urandom), 16'($urandom), 16'($urandom));
            done++;
          end
          default: begin
            send_beat(OP_LOAD, 16'($urandom), 16'($urandom), 16'($urandom));
            done++;
          end
        endcase
      end
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_top_count = 4'd0;
    in_valid = 1'b0;
    in_op = OP_CLEAR;
    in_coord_x = '0;
    in_coord_y = '0;
    in_site_weight_in = '0;
    tx_idle_pct = 8;
    rx_idle_pct = 88;
    rx_hold = 0;
    beats_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extreme sites, a tie, unused op, k settings
    write_top_count(4'd1);
    send_beat(OP_QUERY, 16'h0000, 16'h0000, 16'h0000);
    send_beat(OP_LOAD, 16'h8000, 16'h8000, 16'h0000);
    send_beat(OP_LOAD, 16'h7fff, 16'h7fff, 16'hffff);
    send_beat(OP_LOAD, 16'h7fff, 16'h8000, 16'h0001);
    send_beat(OP_LOAD, 16'h0010, 16'h0000, 16'h0000);
    send_beat(OP_LOAD, 16'h0000, 16'h0010, 16'h0000);
    send_beat(OP_NONE, 16'hffff, 16'hffff, 16'hffff);
    send_beat(OP_QUERY, 16'h0000, 16'h0000, 16'hffff);
    send_beat(OP_QUERY, 16'h8000, 16'h7fff, 16'h0000);
    drain();
    write_top_count(4'd15);
    send_beat(OP_QUERY, 16'h7fff, 16'h8000, 16'h0000);
    drain();
    write_top_count(4'd0);
    send_beat(OP_QUERY, 16'h8000, 16'h8000, 16'h0000);
    drain();
    write_top_count(4'd8);
    send_beat(OP_QUERY, 16'h0000, 16'h0000, 16'h0000);
    send_beat(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    send_beat(OP_QUERY, 16'h0000, 16'h0000, 16'h0000);
    send_beat(OP_LOAD, 16'h0040, 16'hffc0, 16'h0020);
    send_beat(OP_QUERY, 16'h0000, 16'h0000, 16'h0000);
    drain();

    write_top_count(4'($urandom_range(7, 2)));
    random_items(34);
    drain();

    tx_idle_pct = 88;
    rx_idle_pct = 8;
    write_top_count(4'd8);
    random_items(33);
    drain();

    // no idling; hold the result side long enough for the input to back up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_top_count(4'd15);
    rx_hold = 400;
    random_items(33);
    drain();
    repeat (100) @(posedge clk);

    $display("Covered %0d input beats, %0d queries, %0d result beats checked.",
             beats_sent, board.queries, board.hits_seen);
    $display("Settings of k from 0 to 15, empty tables, three idle patterns.");
    if (board.errors == 0 && board.hits_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Mismatches: %0d, results still owed: %0d", board.errors,
               board.hits_due.size());
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
